/* hdl/canrx_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN receive mailbox package
// Shared types, request and response layouts, operation codes and the
// constants of the frame bit counter and the bus load divider.
// ----------------------------------------------------------------------------
package canrx_pkg;

   // Table size default for the top-level parameter.
   localparam int TABLE_ENTRIES_DEFAULT = 16;

   // Field widths.
   localparam int ID_W      = 29;
   localparam int LEN_W     = 4;
   localparam int PAYLOAD_W = 64;
   localparam int MATCH_W   = 32;
   localparam int LOAD_W    = 8;
   localparam int TOTAL_W   = 32;
   localparam int FRAME_W   = 8;

   // Frame length limits and worst-case stuffed bit counts.
   localparam logic [LEN_W-1:0]   MAX_BYTES = 4'd8;
   localparam logic [FRAME_W-1:0] BITS_EXT  = 8'd80;
   localparam logic [FRAME_W-1:0] BITS_STD  = 8'd55;

   // Bus load: percent of a 1 Mbit/s line over one second.
   localparam int LINE_RATE     = 1000000;
   localparam int PERCENT_SCALE = 100;
   localparam int LOAD_DIVISOR  = LINE_RATE / PERCENT_SCALE;
   localparam int LOAD_SAT_BITS = LOAD_DIVISOR * (2 ** LOAD_W);
   localparam int REM_W         = $clog2(LOAD_SAT_BITS);
   // Scaled reciprocal of the divisor; exact for every count below saturation.
   localparam int     RECIP_SHIFT = 34;
   localparam longint LOAD_RECIP  =
      ((longint'(1) << RECIP_SHIFT) + LOAD_DIVISOR - 1) / LOAD_DIVISOR;
   localparam int     RECIP_W     = $clog2(LOAD_RECIP);
   localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

   // Operation codes.
   typedef enum logic [1:0] {
      OP_RECEIVE  = 2'd0,
      OP_TRANSMIT = 2'd1,
      OP_QUERY    = 2'd2,
      OP_TICK     = 2'd3
   } op_type;

   // One request.
   typedef struct packed {
      logic [1:0]           operation;
      logic [ID_W-1:0]      frame_id;
      logic                 extended;
      logic [LEN_W-1:0]     byte_count;
      logic [PAYLOAD_W-1:0] payload_bytes;
      logic [MATCH_W-1:0]   match_value;
      logic [MATCH_W-1:0]   match_mask;
   } req_type;

   // One response.
   typedef struct packed {
      logic                 hit;
      logic [ID_W-1:0]      hit_id;
      logic [LEN_W-1:0]     hit_length;
      logic [PAYLOAD_W-1:0] hit_payload;
      logic                 dropped;
      logic [LOAD_W-1:0]    load_percent;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic scan_read;
      logic div_init;
      logic div_step;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type op;
   } status_type;

endpackage

/* hdl/canrx_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN receive mailbox controller
// Sequences one request: dispatch on the operation, scan the table, run the
// bus load divider, commit the result and strobe the response.
// ----------------------------------------------------------------------------
module canrx_ctrl import canrx_pkg::*; #(
   parameter int  TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT,
   localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  status_type      status,
   output logic            busy,
   output logic            rsp_strobe,
   output cmd_type         cmd,
   output logic [IdxW-1:0] scan_addr
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_DRAIN,
      ST_DIVIDE,
      ST_COMMIT
   } state_type;

   localparam logic [IdxW-1:0] LastAddr = IdxW'(TABLE_ENTRIES - 1);

   state_type         state_ff, state_in;
   logic [IdxW-1:0]   addr_ff, addr_in;
   logic              strobe_ff, strobe_in;

   // Next state and counters.
   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      strobe_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            addr_in = '0;
            case (status.op)
               OP_RECEIVE:  state_in = ST_SCAN;
               OP_QUERY:    state_in = ST_SCAN;
               OP_TICK:     state_in = ST_DIVIDE;
               default:     state_in = ST_COMMIT;
            endcase
         end
         ST_SCAN: begin
            if (addr_ff == LastAddr) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_DIVIDE: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         addr_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         addr_ff   <= addr_in;
         strobe_ff <= strobe_in;
      end
   end

   // Commands decoded from the state.
   always_comb begin
      cmd.load      = (state_ff == ST_IDLE) && start;
      cmd.scan_read = (state_ff == ST_SCAN);
      cmd.div_init  = (state_ff == ST_DISPATCH) && (status.op == OP_TICK);
      cmd.div_step  = (state_ff == ST_DIVIDE);
      cmd.commit    = (state_ff == ST_COMMIT);
   end

   assign scan_addr  = addr_ff;
   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

   // An accepted request makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not make the block busy");

   // Every response strobe follows a commit cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(cmd.commit))
      else $error("response strobe without a commit");

   // Commit is always followed by a response strobe and a free block.
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (rsp_strobe && !busy))
      else $error("commit not followed by a response");

endmodule

/* hdl/canrx_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN receive mailbox datapath
// Holds the request, the mailbox table memory with its used and fresh bits,
// the scan compare, the bit accumulator and the bus load divider.
// ----------------------------------------------------------------------------
module canrx_dp import canrx_pkg::*; #(
   parameter int  TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT,
   localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic            clock,
   input  logic            reset,
   input  req_type         req_data,
   input  cmd_type         cmd,
   input  logic [IdxW-1:0] scan_addr,
   output status_type      status,
   output rsp_type         rsp_data
);

   localparam logic [RECIP_W-1:0] Recip    = RECIP_W'(LOAD_RECIP);
   localparam logic [TOTAL_W-1:0] SatLimit = TOTAL_W'(LOAD_SAT_BITS);

   // Request and response registers.
   req_type req_ff;
   rsp_type rsp_ff, rsp_in;

   // Table storage.
   logic [ID_W-1:0]          slot_id_mem      [TABLE_ENTRIES];
   logic [LEN_W-1:0]         slot_length_mem  [TABLE_ENTRIES];
   logic [PAYLOAD_W-1:0]     slot_payload_mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] slot_used_ff;
   logic [TABLE_ENTRIES-1:0] slot_fresh_ff;

   // Scan read port and compare results.
   logic [ID_W-1:0]      rd_id_ff;
   logic [LEN_W-1:0]     rd_length_ff;
   logic [PAYLOAD_W-1:0] rd_payload_ff;
   logic [IdxW-1:0]      rd_idx_ff;
   logic                 rd_valid_ff;
   logic                 found_ff;
   logic [IdxW-1:0]      found_idx_ff;
   logic                 free_ff;
   logic [IdxW-1:0]      free_idx_ff;
   logic [ID_W-1:0]      cap_id_ff;
   logic [LEN_W-1:0]     cap_length_ff;
   logic [PAYLOAD_W-1:0] cap_payload_ff;

   // Bit accumulator, load value and divider.
   logic [TOTAL_W-1:0] bit_total_ff;
   logic [LOAD_W-1:0]  load_ff;
   logic [REM_W-1:0]   rem_ff;
   logic [LOAD_W-1:0]  quo_ff;
   logic               sat_ff;

   op_type                     op;
   logic [LEN_W-1:0]           len_clamped;
   logic [PAYLOAD_W-1:0]       kept_payload;
   logic [FRAME_W-1:0]         frame_bits;
   logic [TOTAL_W:0]           bit_sum;
   logic [TOTAL_W-1:0]         bit_total_sat;
   logic                       entry_used;
   logic                       entry_match;
   logic [REM_W+RECIP_W-1:0]   product;
   logic [LOAD_W-1:0]          load_next;
   logic                       store_ok;
   logic [IdxW-1:0]            target_idx;

   assign op            = op_type'(req_ff.operation);
   assign status.op     = op;

   // Length clamp and the bytes kept from the payload.
   always_comb begin
      len_clamped = (req_ff.byte_count > MAX_BYTES) ? MAX_BYTES : req_ff.byte_count;
      for (int b = 0; b < 8; b++) begin
         kept_payload[b*8 +: 8] = (LEN_W'(b) < len_clamped) ?
                                  req_ff.payload_bytes[b*8 +: 8] : 8'h00;
      end
   end

   // Worst-case stuffed frame length and saturating accumulate.
   always_comb begin
      frame_bits = ((op == OP_RECEIVE) && !req_ff.extended) ? BITS_STD : BITS_EXT;
      frame_bits = frame_bits + FRAME_W'({len_clamped, 3'b000})
                              + FRAME_W'({len_clamped, 1'b0});
      bit_sum       = {1'b0, bit_total_ff} + (TOTAL_W+1)'(frame_bits);
      bit_total_sat = bit_sum[TOTAL_W] ? '1 : bit_sum[TOTAL_W-1:0];
   end

   // Compare of the entry that the scan read back.
   always_comb begin
      entry_used = slot_used_ff[rd_idx_ff];
      if (op == OP_RECEIVE) begin
         entry_match = entry_used && (rd_id_ff == req_ff.frame_id);
      end else begin
         entry_match = entry_used && slot_fresh_ff[rd_idx_ff] &&
                       ((MATCH_W'(rd_id_ff) & req_ff.match_mask) == req_ff.match_value);
      end
   end

   // Divide by the line-rate scale through a reciprocal multiply.
   always_comb begin
      product   = {{RECIP_W{1'b0}}, rem_ff} * {{REM_W{1'b0}}, Recip};
      load_next = (op == OP_TICK) ? (sat_ff ? LOAD_MAX : quo_ff) : load_ff;
   end

   // Target slot for a received frame.
   assign store_ok   = found_ff || free_ff;
   assign target_idx = found_ff ? found_idx_ff : free_idx_ff;

   // Response fields.
   always_comb begin
      rsp_in              = '0;
      rsp_in.hit          = (op == OP_QUERY) && found_ff;
      rsp_in.hit_id       = rsp_in.hit ? cap_id_ff : '0;
      rsp_in.hit_length   = rsp_in.hit ? cap_length_ff : '0;
      rsp_in.hit_payload  = rsp_in.hit ? cap_payload_ff : '0;
      rsp_in.dropped      = (op == OP_RECEIVE) && !store_ok;
      rsp_in.load_percent = load_next;
   end

   // Control state: table bits, scan flags, accumulator and load value.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_used_ff  <= '0;
         slot_fresh_ff <= '0;
         rd_valid_ff   <= 1'b0;
         found_ff      <= 1'b0;
         free_ff       <= 1'b0;
         bit_total_ff  <= '0;
         load_ff       <= '0;
      end else begin
         rd_valid_ff <= cmd.scan_read;
         if (cmd.load) begin
            found_ff <= 1'b0;
            free_ff  <= 1'b0;
         end else if (rd_valid_ff) begin
            if (entry_match && !found_ff) begin
               found_ff <= 1'b1;
            end
            if ((op == OP_RECEIVE) && !entry_used && !free_ff) begin
               free_ff <= 1'b1;
            end
         end
         if (cmd.commit) begin
            case (op)
               OP_RECEIVE: begin
                  bit_total_ff <= bit_total_sat;
                  if (store_ok) begin
                     slot_used_ff[target_idx]  <= 1'b1;
                     slot_fresh_ff[target_idx] <= 1'b1;
                  end
               end
               OP_TRANSMIT: begin
                  bit_total_ff <= bit_total_sat;
               end
               OP_QUERY: begin
                  if (found_ff) begin
                     slot_fresh_ff[found_idx_ff] <= 1'b0;
                  end
               end
               OP_TICK: begin
                  load_ff      <= load_next;
                  bit_total_ff <= '0;
               end
               default: begin
                  load_ff <= load_ff;
               end
            endcase
         end
      end
   end

   // Payload registers: request, captures, divider and response.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (rd_valid_ff && !cmd.load) begin
         if (entry_match && !found_ff) begin
            found_idx_ff   <= rd_idx_ff;
            cap_id_ff      <= rd_id_ff;
            cap_length_ff  <= rd_length_ff;
            cap_payload_ff <= rd_payload_ff;
         end
         if (!entry_used && !free_ff) begin
            free_idx_ff <= rd_idx_ff;
         end
      end
      if (cmd.div_init) begin
         sat_ff <= (bit_total_ff >= SatLimit);
         rem_ff <= bit_total_ff[REM_W-1:0];
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= product[RECIP_SHIFT +: LOAD_W];
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   // Table memory: one write port at commit, one registered scan read.
   always_ff @(posedge clock) begin
      if (cmd.commit && (op == OP_RECEIVE) && store_ok) begin
         slot_id_mem[target_idx]      <= req_ff.frame_id;
         slot_length_mem[target_idx]  <= len_clamped;
         slot_payload_mem[target_idx] <= kept_payload;
      end
      if (cmd.scan_read) begin
         rd_id_ff      <= slot_id_mem[scan_addr];
         rd_length_ff  <= slot_length_mem[scan_addr];
         rd_payload_ff <= slot_payload_mem[scan_addr];
         rd_idx_ff     <= scan_addr;
      end
   end

   assign rsp_data = rsp_ff;

   // A fresh mark only sits on a used slot.
   assert property (@(posedge clock) disable iff (reset)
      (slot_fresh_ff & ~slot_used_ff) == '0)
      else $error("fresh mark on an unused slot");

   // Slots are never released once used.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((slot_used_ff & $past(slot_used_ff)) == $past(slot_used_ff)))
      else $error("used slot was released");

   // A commit never reports both a hit and a dropped frame.
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_in.hit && rsp_in.dropped))
      else $error("hit and dropped both set");

endmodule

/* hdl/can_rx_mailbox_with_bus_load_unit.sv */
`timescale 1ns / 1ps
// A receive or query request passes the dispatch state, the scan of the table memory read
// port at one slot per cycle, the drain state and the commit state before it is strobed; a
// transmit goes from dispatch to commit, and a tick passes the divide state of the divider.
// One request at a time; busy drops in the response cycle, so the next request is accepted
// there. Responses cannot stall.
// Reset clears the used and fresh bits, the bit accumulator and the load value.
// ----------------------------------------------------------------------------
// CAN receive mailbox with bus load meter
// Stores received frames by identifier, answers filtered queries for fresh
// frames and reports the bus load as a percentage at each one-second tick.
// ----------------------------------------------------------------------------
module can_rx_mailbox_with_bus_load_unit import canrx_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   cmd_type         cmd;
   status_type      status;
   logic [IdxW-1:0] scan_addr;

   // Request sequencer.
   canrx_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .scan_addr  (scan_addr)
   );

   // Table, accumulator and divider.
   canrx_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .scan_addr (scan_addr),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/mailbox_scoreboard_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mailbox scoreboard
// Keeps a shadow copy of the mailbox table and the bus load meter, predicts
// the response of every accepted request and checks each strobed response
// against the oldest prediction.
// ----------------------------------------------------------------------------
package mailbox_scoreboard_pkg;
   import canrx_pkg::*;

   localparam int SLOTS        = TABLE_ENTRIES_DEFAULT;
   localparam int REPORT_LIMIT = 40;

   class mailbox_scoreboard;
      bit                   slot_used[SLOTS];
      bit                   slot_fresh[SLOTS];
      logic [ID_W-1:0]      slot_id[SLOTS];
      logic [LEN_W-1:0]     slot_len[SLOTS];
      logic [PAYLOAD_W-1:0] slot_payload[SLOTS];
      logic [TOTAL_W-1:0]   bit_total;
      logic [LOAD_W-1:0]    load_value;
      rsp_type              pending_responses[$];
      int                   mismatches;

      function new();
         foreach (slot_used[i]) begin
            slot_used[i]    = 1'b0;
            slot_fresh[i]   = 1'b0;
            slot_id[i]      = '0;
            slot_len[i]     = '0;
            slot_payload[i] = '0;
         end
         bit_total  = '0;
         load_value = '0;
         mismatches = 0;
      endfunction

      // The accumulator saturates instead of wrapping.
      function void add_frame_bits(logic [FRAME_W-1:0] bits);
         logic [TOTAL_W:0] sum;
         sum = {1'b0, bit_total} + bits;
         bit_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
      endfunction

      // Predict the one response that a request produces and update the state.
      function rsp_type compute_response(req_type r);
         rsp_type              rsp;
         logic [LEN_W-1:0]     len;
         logic [PAYLOAD_W-1:0] kept;
         logic [MATCH_W-1:0]   wide_id;
         logic [63:0]          pct;
         int                   target;
         rsp = '0;
         len = (r.byte_count > MAX_BYTES) ? MAX_BYTES : r.byte_count;
         case (r.operation)
            OP_RECEIVE: begin
               // An equal identifier wins over the first free slot.
               target = -1;
               for (int i = 0; i < SLOTS; i++) begin
                  if (target < 0 && slot_used[i] && slot_id[i] == r.frame_id) target = i;
               end
               for (int i = 0; i < SLOTS; i++) begin
                  if (target < 0 && !slot_used[i]) target = i;
               end
               if (len >= MAX_BYTES) begin
                  kept = r.payload_bytes;
               end else begin
                  kept = r.payload_bytes & ((64'd1 << {len, 3'b000}) - 64'd1);
               end
               if (target >= 0) begin
                  slot_used[target]    = 1'b1;
                  slot_fresh[target]   = 1'b1;
                  slot_id[target]      = r.frame_id;
                  slot_len[target]     = len;
                  slot_payload[target] = kept;
               end else begin
                  rsp.dropped = 1'b1;
               end
               add_frame_bits(FRAME_W'((r.extended ? BITS_EXT : BITS_STD) + len * 10));
            end
            OP_TRANSMIT: begin
               // Transmitted frames always count as extended.
               add_frame_bits(FRAME_W'(BITS_EXT + len * 10));
            end
            OP_QUERY: begin
               for (int i = 0; i < SLOTS; i++) begin
                  wide_id = MATCH_W'(slot_id[i]);
                  if (!rsp.hit && slot_used[i] && slot_fresh[i] &&
                      (wide_id & r.match_mask) == r.match_value) begin
                     rsp.hit         = 1'b1;
                     rsp.hit_id      = slot_id[i];
                     rsp.hit_length  = slot_len[i];
                     rsp.hit_payload = slot_payload[i];
                     slot_fresh[i]   = 1'b0;
                  end
               end
            end
            default: begin
               // Percent of the line rate, saturating at the top of the field.
               pct = 64'(bit_total);
               pct = pct * PERCENT_SCALE / LINE_RATE;
               load_value = (pct > LOAD_MAX) ? LOAD_MAX : pct[LOAD_W-1:0];
               bit_total = '0;
            end
         endcase
         rsp.load_percent = load_value;
         return rsp;
      endfunction

      function void note_request(req_type r);
         pending_responses.push_back(compute_response(r));
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      task compare_field(string name, logic [PAYLOAD_W-1:0] got, logic [PAYLOAD_W-1:0] want);
         if (got !== want) report($sformatf("%s got %h, expected %h", name, got, want));
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (pending_responses.size() == 0) begin
            report("response strobed with no request outstanding");
         end else begin
            want = pending_responses.pop_front();
            compare_field("hit", PAYLOAD_W'(got.hit), PAYLOAD_W'(want.hit));
            compare_field("hit_id", PAYLOAD_W'(got.hit_id), PAYLOAD_W'(want.hit_id));
            compare_field("hit_length", PAYLOAD_W'(got.hit_length),
                          PAYLOAD_W'(want.hit_length));
            compare_field("hit_payload", got.hit_payload, want.hit_payload);
            compare_field("dropped", PAYLOAD_W'(got.dropped), PAYLOAD_W'(want.dropped));
            compare_field("load_percent", PAYLOAD_W'(got.load_percent),
                          PAYLOAD_W'(want.load_percent));
         end
      endtask
   endclass

endpackage

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN receive mailbox testbench
// Drives directed and random receive, transmit, query and tick requests with
// varying sender gaps, and checks every strobed response against the
// scoreboard prediction, including a transmit burst that raises the bus load.
// ----------------------------------------------------------------------------
module tb_top;
   import canrx_pkg::*;
   import mailbox_scoreboard_pkg::*;

   localparam int RANDOM_PER_PHASE = 295;
   localparam int LOAD_BURST       = 96;
   localparam int SETTLE_CYCLES    = TABLE_ENTRIES_DEFAULT + 8;
   localparam int ID_POOL_MAX      = 24;
   localparam int FILL_FRAMES      = 14;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   mailbox_scoreboard frames;
   logic [ID_W-1:0]   seen_ids[$];
   int                idle_plan[4] = '{0, 66, 34, 0};

   can_rx_mailbox_with_bus_load_unit #(
      .TABLE_ENTRIES(TABLE_ENTRIES_DEFAULT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   // Clock with a 12 ns period.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Note accepted requests and check strobed responses at each edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) frames.note_request(req_data);
         if (rsp_strobe) frames.check_response(rsp_data);
      end
   end

   function automatic req_type make_req(input op_type op, input logic [ID_W-1:0] id,
                                        input logic ext, input logic [LEN_W-1:0] len,
                                        input logic [PAYLOAD_W-1:0] payload,
                                        input logic [MATCH_W-1:0] value,
                                        input logic [MATCH_W-1:0] mask);
      req_type r;
      r.operation     = op;
      r.frame_id      = id;
      r.extended      = ext;
      r.byte_count    = len;
      r.payload_bytes = payload;
      r.match_value   = value;
      r.match_mask    = mask;
      return r;
   endfunction

   // Mostly well-formed traffic on identifiers already seen, with some noise.
   function automatic req_type random_request();
      req_type            r;
      logic [ID_W-1:0]    id;
      logic [MATCH_W-1:0] wide_id;
      int                 sel;
      int                 pick;
      r.frame_id      = ID_W'($urandom);
      r.extended      = 1'($urandom);
      r.byte_count    = LEN_W'(($urandom_range(3) == 0) ? $urandom_range(9, 15)
                                                         : $urandom_range(0, 8));
      r.payload_bytes = {$urandom, $urandom};
      r.match_value   = $urandom;
      r.match_mask    = $urandom;
      id = (seen_ids.size() > 0) ? seen_ids[$urandom_range(0, seen_ids.size() - 1)]
                                 : ID_W'($urandom);
      wide_id = MATCH_W'(id);
      sel = $urandom_range(99);
      if (sel < 40) begin
         r.operation = OP_RECEIVE;
         if ($urandom_range(99) < 85) r.frame_id = id;
      end else if (sel < 55) begin
         r.operation = OP_TRANSMIT;
      end else if (sel < 90) begin
         r.operation = OP_QUERY;
         pick = $urandom_range(9);
         if (pick < 7) begin
            r.match_value = wide_id & r.match_mask;
         end else if (pick < 8) begin
            r.match_value = '0;
            r.match_mask  = '0;
         end
      end else begin
         r.operation = OP_TICK;
      end
      return r;
   endfunction

   // Present one request, after an optional gap, and hold it until accepted.
   task automatic send_request(input req_type item, input int idle_pct);
      bit known;
      known = 1'b0;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
      if (item.operation == OP_RECEIVE) begin
         foreach (seen_ids[k]) begin
            if (seen_ids[k] == item.frame_id) known = 1'b1;
         end
         if (!known && seen_ids.size() < ID_POOL_MAX) seen_ids.push_back(item.frame_id);
      end
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Hold off new requests until every predicted response has been strobed.
   task automatic drain_responses();
      start <= 1'b0;
      do @(negedge clock); while (frames.pending_responses.size() != 0);
      @(posedge clock);
   endtask

   initial begin
      frames = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table: a catch-all query misses, a tick reports zero load.
      send_request(make_req(OP_QUERY, '0, 1'b0, '0, '0, '0, '0), 0);
      send_request(make_req(OP_TICK, '0, 1'b0, '0, '0, '0, '0), 0);
      // Short, full, clamped and partial frames; unused payload bytes are zeroed.
      send_request(make_req(OP_RECEIVE, '0, 1'b0, 4'd0, '1, '0, '0), 0);
      send_request(make_req(OP_RECEIVE, '1, 1'b1, 4'd8, '1, '0, '0), 0);
      send_request(make_req(OP_RECEIVE, 29'h155, 1'b0, 4'd15,
                            64'hA5A5_5A5A_C3C3_3C3C, '0, '0), 0);
      send_request(make_req(OP_RECEIVE, 29'h2AA, 1'b1, 4'd3, '1, '0, '0), 0);
      // Transmit counts as extended whatever the extended flag says.
      send_request(make_req(OP_TRANSMIT, '1, 1'b0, 4'd0, '1, '1, '1), 0);
      send_request(make_req(OP_TRANSMIT, '0, 1'b1, 4'd15, '0, '0, '0), 0);
      // Same identifier again overwrites its slot in place.
      send_request(make_req(OP_RECEIVE, '0, 1'b1, 4'd8,
                            64'h0123_4567_89AB_CDEF, '0, '0), 0);
      // Exact match hits once, then the entry is no longer fresh.
      send_request(make_req(OP_QUERY, '0, 1'b0, '0, '0, 32'h1FFF_FFFF, '1), 0);
      send_request(make_req(OP_QUERY, '0, 1'b0, '0, '0, 32'h1FFF_FFFF, '1), 0);
      // A filter with bits above the identifier width can never match.
      send_request(make_req(OP_QUERY, '0, 1'b0, '0, '0, 32'hE000_0000, '1), 0);
      send_request(make_req(OP_QUERY, '0, 1'b0, '0, '0, '0, '0), 0);
      send_request(make_req(OP_TICK, '0, 1'b0, '0, '0, '0, '0), 0);
      // Fill the table and overflow it so that new identifiers are dropped.
      for (int k = 0; k < FILL_FRAMES; k++) begin
         send_request(make_req(OP_RECEIVE, ID_W'(32'h1000 + k * 32'h1111), 1'($urandom),
                               LEN_W'($urandom_range(0, 15)), {$urandom, $urandom},
                               '0, '0), 0);
      end
      drain_responses();

      // Back-to-back transmits build up a nonzero load for the next tick.
      for (int n = 0; n < LOAD_BURST; n++) begin
         send_request(make_req(OP_TRANSMIT, ID_W'($urandom), 1'($urandom),
                               LEN_W'($urandom_range(8, 15)), {$urandom, $urandom},
                               $urandom, $urandom), 0);
      end
      send_request(make_req(OP_TICK, '0, 1'b0, '0, '0, '0, '0), 0);
      send_request(make_req(OP_TICK, '0, 1'b0, '0, '0, '0, '0), 0);
      drain_responses();

      // Random traffic in phases of different sender gaps.
      foreach (idle_plan[p]) begin
         repeat (RANDOM_PER_PHASE) send_request(random_request(), idle_plan[p]);
         drain_responses();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (frames.pending_responses.size() != 0) frames.report("responses still outstanding");
      if (frames.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog for a block that stops responding.
   initial begin
      #8_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

/* sim.f */
hdl/canrx_pkg.sv
hdl/canrx_ctrl.sv
hdl/canrx_dp.sv
hdl/can_rx_mailbox_with_bus_load_unit.sv
tb/mailbox_scoreboard_pkg.sv
tb/tb_top.sv
